FILE: src/cgs_pkg.sv
// ----------------------------------------------------------------------------
// cgs_pkg
// Shared types, codes and fixed-point helpers of the conjugate gradient solver.
// ----------------------------------------------------------------------------
package cgs_pkg;

  localparam int MAX_DIM_DEF = 16;
  localparam int RESULT_CAP  = 16;

  typedef enum logic [1:0] {
    KIND_LOAD_A = 2'd0,
    KIND_LOAD_B = 2'd1,
    KIND_START  = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_CONVERGED = 2'd0,
    ST_LIMIT     = 2'd1,
    ST_BREAKDOWN = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CFG_ACTIVE_SIZE = 2'd0,
    CFG_MAX_ITER    = 2'd1,
    CFG_TOLERANCE   = 2'd2
  } cfg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INIT,
    S_CHK,
    S_MV,
    S_PAP,
    S_DIVA,
    S_UPX,
    S_UPR,
    S_RR,
    S_DIVB,
    S_UPP,
    S_OUT
  } state_t;

  localparam logic signed [63:0] Q32_MAX = 64'sd2147483647;
  localparam logic signed [63:0] Q32_MIN = -64'sd2147483648;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > Q32_MAX) r = 32'sh7FFF_FFFF;
    else if (v < Q32_MIN) r = 32'sh8000_0000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
    logic signed [63:0] s;
    logic signed [63:0] r;
    s = a + b;
    if (!a[63] && !b[63] && s[63]) r = 64'sh7FFF_FFFF_FFFF_FFFF;
    else if (a[63] && b[63] && !s[63]) r = 64'sh8000_0000_0000_0000;
    else r = s;
    return r;
  endfunction

endpackage

FILE: src/cgs_if.sv
// ----------------------------------------------------------------------------
// cgs interfaces
// Request, result and configuration channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface cgs_req_if;
  logic               valid;
  logic               ready;
  logic        [1:0]  kind;
  logic        [3:0]  row;
  logic        [3:0]  col;
  logic signed [31:0] element_value;
  modport source(output valid, kind, row, col, element_value, input ready);
  modport sink(input valid, kind, row, col, element_value, output ready);
endinterface

interface cgs_rsp_if;
  logic               valid;
  logic               ready;
  logic        [3:0]  index;
  logic signed [31:0] solution_value;
  logic               last;
  logic        [1:0]  status;
  logic        [15:0] iterations_used;
  modport source(output valid, index, solution_value, last, status, iterations_used,
                 input ready);
  modport sink(input valid, index, solution_value, last, status, iterations_used,
               output ready);
endinterface

interface cgs_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

FILE: src/conjugate_gradient_solver.sv
// ----------------------------------------------------------------------------
// conjugate_gradient_solver
// Fixed-point conjugate gradient solver for symmetric positive definite A.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one item per handshake. Load items (kind 0 and 1) write one
//   element of A or b and are taken every cycle while the block is idle.
//   A start item (kind 2) runs the solve from x = 0; req.ready stays low from
//   then until the last solution item has been taken on rsp.
//   rsp gives n items, index 0 first, each with last, status and the count.
//   cfg writes active_size, max_iterations and tolerance; it is always ready.
//   The user writes it only while the block is idle; this is not enforced.
// Datapath:
//   Vectors live in small synchronous RAMs and are processed one element at
//   a time (address, multiply, accumulate or write back) on a single 32x32
//   multiplier. Each iteration makes an n*n matrix-vector pass and two
//   divides, for alpha and beta. A result item is held for as long as the
//   receiver holds rsp.ready low.
// Reset: control state, configuration and old residual norm are cleared to
//   their defaults; matrix and vector RAMs are not cleared.
// ----------------------------------------------------------------------------
module conjugate_gradient_solver #(
  parameter int MAX_DIM = cgs_pkg::MAX_DIM_DEF
) (
  input  logic     clk,
  input  logic     rst,
  cgs_req_if.sink  req,
  cgs_rsp_if.source rsp,
  cgs_cfg_if.sink  cfg
);

  import cgs_pkg::*;

  localparam int IW  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int AAW = $clog2(MAX_DIM * MAX_DIM);
  localparam int CAP = (MAX_DIM < RESULT_CAP) ? MAX_DIM : RESULT_CAP;

  // configuration
  logic [4:0]  active_size;
  logic [15:0] max_iterations;
  logic [30:0] tolerance;

  // control
  state_t      state, state_next;
  logic [1:0]  ph;
  logic [IW-1:0] i, j, nm1;
  logic [15:0] it;
  logic [15:0] limit;
  logic [61:0] tol2;
  status_t     status;
  logic [15:0] used;

  // datapath
  logic signed [63:0] acc, acc_sum, prod, old_norm, dsum, t;
  logic signed [31:0] step;
  logic signed [31:0] ma, mb;
  logic signed [31:0] x_upd, r_upd, p_upd;

  // memories
  logic [31:0] a_rd, b_rd, x_rd, r_rd, p_rd, ap_rd;
  logic           a_we, b_we, x_we, r_we, p_we, ap_we;
  logic [AAW-1:0] a_addr_w, a_addr_r;
  logic [IW-1:0]  b_addr_w, p_addr_r;
  logic [31:0]    x_wd, r_wd, p_wd;

  // divider
  logic               div_start, div_done;
  logic signed [63:0] div_num, div_den;
  logic signed [31:0] div_q;

  // output register
  logic               out_valid;
  logic [3:0]         out_index;
  logic signed [31:0] out_value;
  logic               out_last;
  status_t            out_status;
  logic [15:0]        out_used;

  logic req_acc, rsp_acc, elem_end, pass_end, is_start;
  logic [4:0] eff;

  assign req_acc  = req.valid && req.ready;
  assign rsp_acc  = rsp.valid && rsp.ready;
  assign is_start = req_acc && (kind_t'(req.kind) == KIND_START);
  assign elem_end = (ph == 2'd2);
  assign pass_end = elem_end && (i == nm1);
  assign acc_sum  = sat_add64(acc, prod);
  assign t        = prod >>> 16;
  assign x_upd    = sat32(64'(signed'(x_rd)) + t);
  assign r_upd    = sat32(64'(signed'(r_rd)) - t);
  assign p_upd    = sat32(64'(signed'(r_rd)) + t);

  // effective dimension: zero counts as one, capped by storage and result count
  always_comb begin
    eff = (active_size == 5'd0) ? 5'd1 : active_size;
    if (int'(eff) > CAP) eff = 5'(CAP);
  end

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_size    <= 5'd16;
      max_iterations <= 16'd100;
      tolerance      <= 31'd66;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg_idx_t'(cfg.index))
        CFG_ACTIVE_SIZE: active_size    <= cfg.data[4:0];
        CFG_MAX_ITER:    max_iterations <= cfg.data[15:0];
        CFG_TOLERANCE:   tolerance      <= cfg.data[30:0];
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (is_start) state_next = S_INIT;
      S_INIT: if (pass_end) state_next = S_CHK;
      S_CHK:  state_next = (it < limit) ? S_MV : S_OUT;
      S_MV:   if (pass_end && j == nm1) state_next = S_PAP;
      S_PAP:  if (pass_end) state_next = (acc_sum == 64'sd0) ? S_OUT : S_DIVA;
      S_DIVA: if (div_done) state_next = S_UPX;
      S_UPX:  if (pass_end) state_next = S_UPR;
      S_UPR:  if (pass_end) state_next = S_RR;
      S_RR: begin
        if (pass_end) state_next = (unsigned'(acc_sum) < {2'b00, tol2}) ? S_OUT : S_DIVB;
      end
      S_DIVB: if (div_done) state_next = S_UPP;
      S_UPP:  if (pass_end) state_next = S_CHK;
      S_OUT:  if (rsp_acc && i == nm1) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // outputs: handshake, memory ports, multiplier operands, divider launch
  always_comb begin
    req.ready = (state == S_IDLE);
    a_we      = 1'b0;
    b_we      = 1'b0;
    x_we      = 1'b0;
    r_we      = 1'b0;
    p_we      = 1'b0;
    ap_we     = 1'b0;
    x_wd      = x_upd;
    r_wd      = r_upd;
    p_wd      = p_upd;
    a_addr_w  = AAW'(int'(req.row) * MAX_DIM + int'(req.col));
    b_addr_w  = IW'(req.row);
    a_addr_r  = AAW'(int'(i) * MAX_DIM + int'(j));
    p_addr_r  = i;
    ma        = signed'(b_rd);
    mb        = signed'(b_rd);
    div_start = 1'b0;
    div_num   = old_norm;
    div_den   = dsum;
    unique case (state)
      S_IDLE: begin
        if (req_acc && kind_t'(req.kind) == KIND_LOAD_A &&
            int'(req.row) < MAX_DIM && int'(req.col) < MAX_DIM) begin
          a_we = 1'b1;
        end
        if (req_acc && kind_t'(req.kind) == KIND_LOAD_B && int'(req.row) < MAX_DIM) begin
          b_we = 1'b1;
        end
      end
      S_INIT: begin
        x_we = elem_end;
        r_we = elem_end;
        p_we = elem_end;
        x_wd = '0;
        r_wd = b_rd;
        p_wd = b_rd;
      end
      S_MV: begin
        p_addr_r = j;
        ma       = signed'(a_rd);
        mb       = signed'(p_rd);
        ap_we    = elem_end && (j == nm1);
      end
      S_PAP: begin
        ma = signed'(p_rd);
        mb = signed'(ap_rd);
      end
      S_DIVA: div_start = (ph == 2'd0);
      S_UPX: begin
        ma   = step;
        mb   = signed'(p_rd);
        x_we = elem_end;
      end
      S_UPR: begin
        ma   = step;
        mb   = signed'(ap_rd);
        r_we = elem_end;
      end
      S_RR: begin
        ma = signed'(r_rd);
        mb = signed'(r_rd);
      end
      S_DIVB: begin
        div_start = (ph == 2'd0);
        div_num   = dsum;
        div_den   = old_norm;
      end
      S_UPP: begin
        ma   = step;
        mb   = signed'(p_rd);
        p_we = elem_end;
      end
      S_CHK, S_OUT: ;
      default: ;
    endcase
  end

  // sequencer registers and datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ph        <= '0;
      i         <= '0;
      j         <= '0;
      acc       <= '0;
      old_norm  <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      prod  <= ma * mb;
      unique case (state)
        S_IDLE: begin
          if (is_start) begin
            nm1   <= IW'(eff - 5'd1);
            limit <= max_iterations;
            tol2  <= tolerance * tolerance;
            it    <= '0;
            i     <= '0;
            j     <= '0;
            acc   <= '0;
            ph    <= '0;
          end
        end
        S_CHK: begin
          if (it >= limit) begin
            status <= ST_LIMIT;
            used   <= limit;
          end
        end
        S_DIVA, S_DIVB: begin
          // launch, then wait for the quotient
          if (ph == 2'd0) ph <= 2'd1;
          else if (div_done) begin
            ph   <= 2'd0;
            step <= div_q;
          end
        end
        S_OUT: begin
          if (ph == 2'd0) ph <= 2'd1;
          else if (ph == 2'd1) begin
            ph         <= 2'd2;
            out_valid  <= 1'b1;
            out_index  <= 4'(i);
            out_value  <= signed'(x_rd);
            out_last   <= (i == nm1);
            out_status <= status;
            out_used   <= used;
          end else if (rsp_acc) begin
            ph        <= 2'd0;
            out_valid <= 1'b0;
            i         <= (i == nm1) ? '0 : i + 1'b1;
          end
        end
        default: begin
          // each element steps through address, multiply, use
          ph <= elem_end ? 2'd0 : ph + 2'd1;
          if (elem_end) begin
            if (state == S_MV) begin
              if (j == nm1) begin
                j   <= '0;
                i   <= (i == nm1) ? '0 : i + 1'b1;
                acc <= '0;
              end else begin
                j   <= j + 1'b1;
                acc <= acc_sum;
              end
            end else begin
              i <= (i == nm1) ? '0 : i + 1'b1;
              if (state == S_INIT || state == S_PAP || state == S_RR) begin
                acc <= pass_end ? 64'sd0 : acc_sum;
              end
            end
          end
          if (pass_end) begin
            if (state == S_INIT) old_norm <= acc_sum;
            if (state == S_PAP || state == S_RR) dsum <= acc_sum;
            if (state == S_PAP && acc_sum == 64'sd0) begin
              status <= ST_BREAKDOWN;
              used   <= it;
            end
            if (state == S_RR && unsigned'(acc_sum) < {2'b00, tol2}) begin
              status <= ST_CONVERGED;
              used   <= it;
            end
            if (state == S_UPP) begin
              old_norm <= dsum;
              it       <= it + 16'd1;
            end
          end
        end
      endcase
    end
  end

  assign rsp.valid           = out_valid;
  assign rsp.index           = out_index;
  assign rsp.solution_value  = out_value;
  assign rsp.last            = out_last;
  assign rsp.status          = out_status;
  assign rsp.iterations_used = out_used;

  cgs_ram #(.DEPTH(MAX_DIM * MAX_DIM), .WIDTH(32), .AW(AAW)) u_a_ram (
    .clk, .we(a_we), .waddr(a_addr_w), .wdata(req.element_value),
    .raddr(a_addr_r), .rdata(a_rd)
  );

  cgs_ram #(.DEPTH(MAX_DIM), .WIDTH(32), .AW(IW)) u_b_ram (
    .clk, .we(b_we), .waddr(b_addr_w), .wdata(req.element_value),
    .raddr(i), .rdata(b_rd)
  );

  cgs_ram #(.DEPTH(MAX_DIM), .WIDTH(32), .AW(IW)) u_x_ram (
    .clk, .we(x_we), .waddr(i), .wdata(x_wd), .raddr(i), .rdata(x_rd)
  );

  cgs_ram #(.DEPTH(MAX_DIM), .WIDTH(32), .AW(IW)) u_r_ram (
    .clk, .we(r_we), .waddr(i), .wdata(r_wd), .raddr(i), .rdata(r_rd)
  );

  cgs_ram #(.DEPTH(MAX_DIM), .WIDTH(32), .AW(IW)) u_p_ram (
    .clk, .we(p_we), .waddr(i), .wdata(p_wd), .raddr(p_addr_r), .rdata(p_rd)
  );

  cgs_ram #(.DEPTH(MAX_DIM), .WIDTH(32), .AW(IW)) u_ap_ram (
    .clk, .we(ap_we), .waddr(i), .wdata(sat32(acc_sum >>> 16)), .raddr(i), .rdata(ap_rd)
  );

  cgs_div u_div (
    .clk, .rst, .start(div_start), .num(div_num), .den(div_den),
    .done(div_done), .quot(div_q)
  );

endmodule

FILE: src/cgs_ram.sv
// ----------------------------------------------------------------------------
// cgs_ram
// Single-port-write, single-port-read memory with registered read data.
// ----------------------------------------------------------------------------
module cgs_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: src/cgs_div.sv
// ----------------------------------------------------------------------------
// cgs_div
// Q32.32 by Q32.32 divide to saturated Q16.16, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module cgs_div (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [63:0] num,
  input  logic signed [63:0] den,
  output logic               done,
  output logic signed [31:0] quot
);

  import cgs_pkg::*;

  logic        busy;
  logic [6:0]  cnt;
  logic [79:0] dvd;
  logic [63:0] rem;
  logic [63:0] dmag;
  logic        neg;
  logic        dzero;
  logic [64:0] rem2;
  logic        ge;
  logic [32:0] mag;

  assign rem2 = {rem, dvd[79]};
  assign ge   = rem2 >= {1'b0, dmag};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == 7'd1);
      if (start) begin
        busy  <= 1'b1;
        cnt   <= 7'd80;
        neg   <= num[63] != den[63];
        dzero <= den == 64'sd0;
        dmag  <= den[63] ? 64'(-den) : 64'(den);
        dvd   <= {(num[63] ? 64'(-num) : 64'(num)), 16'd0};
        rem   <= '0;
      end else if (busy) begin
        rem <= ge ? 64'(rem2 - {1'b0, dmag}) : rem2[63:0];
        dvd <= {dvd[78:0], ge};
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // saturate the quotient magnitude, then apply the sign
  always_comb begin
    mag = (|dvd[79:32]) ? 33'h1_0000_0000 : {1'b0, dvd[31:0]};
    if (dzero) quot = '0;
    else if (neg) quot = (mag >= 33'h0_8000_0000) ? 32'sh8000_0000 : 32'(-mag);
    else quot = (mag > 33'h0_7FFF_FFFF) ? 32'sh7FFF_FFFF : mag[31:0];
  end

endmodule
